>>> src/ftbp_pkg.sv
package ftbp_pkg;

    localparam int NUM_FLOWS  = 1024;
    localparam int IDX_W      = $clog2(NUM_FLOWS);
    localparam int TIME_W     = 48;
    localparam int NOW_W      = 48;
    localparam int RATE_W     = 32;
    localparam int LVL_W      = 48;
    localparam int ELAP_W     = 32;
    localparam int PROD_W     = ELAP_W + RATE_W;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 48;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 56;

    localparam logic [LVL_W-1:0] ONE_TOKEN = LVL_W'(64'h1_0000_0000);

    localparam logic [CFG_IDX_W-1:0] CFG_REFILL_RATE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = CFG_IDX_W'(1);

    typedef struct packed {
        logic             clear;
        logic [IDX_W-1:0] clear_addr;
        logic             accept;
        logic             elap;
        logic             mul;
        logic             cmp;
        logic             fin;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

>>> src/ftbp_ctrl.sv
module ftbp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  ftbp_pkg::t_sts i_sts,
    output ftbp_pkg::t_cmd o_cmd
);
    import ftbp_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_ELAP  = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_CMP   = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [IDX_W-1:0] r_clr_cnt, n_clr_cnt;
    logic             w_accept;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_state   = r_state;
        n_clr_cnt = r_clr_cnt;
        case (r_state)
            ST_CLEAR: begin
                n_clr_cnt = r_clr_cnt + IDX_W'(1);
                if (r_clr_cnt == IDX_W'(NUM_FLOWS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_ELAP;
                end
            end
            ST_ELAP: n_state = ST_MUL;
            ST_MUL:  n_state = ST_CMP;
            ST_CMP:  n_state = ST_FIN;
            ST_FIN: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_clr_cnt <= n_clr_cnt;
        end
    end

    always_comb begin
        o_cmd.clear      = (r_state == ST_CLEAR);
        o_cmd.clear_addr = r_clr_cnt;
        o_cmd.accept     = w_accept;
        o_cmd.elap       = (r_state == ST_ELAP);
        o_cmd.mul        = (r_state == ST_MUL);
        o_cmd.cmp        = (r_state == ST_CMP);
        o_cmd.fin        = (r_state == ST_FIN) && i_sts.out_free;
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == ST_ELAP)
        else $error("accepted transfer did not start work");

    a_fin_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && !i_sts.out_free) |=> r_state == ST_FIN)
        else $error("result left while output register was full");

    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_CLEAR |-> !s_axis_tready)
        else $error("input ready during clearing pass");

endmodule

>>> src/ftbp_dp.sv
module ftbp_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [ftbp_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [ftbp_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ftbp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ftbp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  ftbp_pkg::t_cmd                    i_cmd,
    output ftbp_pkg::t_sts                    o_sts
);
    import ftbp_pkg::*;

    logic             mem_vld  [NUM_FLOWS];
    logic [LVL_W-1:0] mem_lvl  [NUM_FLOWS];
    logic [TIME_W-1:0] mem_time [NUM_FLOWS];

    logic [RATE_W-1:0] r_rate;
    logic [LVL_W-1:0]  r_cap;

    logic [IDX_W-1:0]  r_idx;
    logic [TIME_W-1:0] r_now;
    logic              r_rd_vld;
    logic [LVL_W-1:0]  r_rd_lvl;
    logic [TIME_W-1:0] r_rd_time;
    logic [ELAP_W-1:0] r_elap;
    logic              r_new;
    logic [PROD_W-1:0] r_added;
    logic [LVL_W-1:0]  r_lvl;

    logic              r_out_valid;
    logic              r_out_allowed;
    logic [LVL_W-1:0]  r_out_tokens;
    logic              r_out_new;

    logic [IDX_W-1:0]  w_in_idx;
    logic [NOW_W-1:0]  w_in_now;
    logic [TIME_W-1:0] w_diff;
    logic [63:0]       w_diff64;
    logic [LVL_W-1:0]  w_cap_eff;
    logic [LVL_W-1:0]  w_room;
    logic              w_full;
    logic              w_allow;
    logic [LVL_W-1:0]  w_fin_lvl;
    logic              w_vld_we;
    logic [IDX_W-1:0]  w_vld_addr;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= '0;
            r_cap  <= ONE_TOKEN;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_REFILL_RATE: r_rate <= i_cfg_data[RATE_W-1:0];
                CFG_CAPACITY:    r_cap  <= i_cfg_data[LVL_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_in_idx = s_axis_tdata[IDX_W-1:0];
    assign w_in_now = s_axis_tdata[IDX_W +: NOW_W];

    assign w_vld_we   = i_cmd.clear || i_cmd.fin;
    assign w_vld_addr = i_cmd.clear ? i_cmd.clear_addr : r_idx;

    always_ff @(posedge i_clk) begin
        if (w_vld_we) begin
            mem_vld[w_vld_addr] <= i_cmd.fin;
        end
        if (i_cmd.accept) begin
            r_rd_vld <= mem_vld[w_in_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            mem_lvl[r_idx]  <= w_fin_lvl;
            mem_time[r_idx] <= r_now;
        end
        if (i_cmd.accept) begin
            r_rd_lvl  <= mem_lvl[w_in_idx];
            r_rd_time <= mem_time[w_in_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_idx <= w_in_idx;
            r_now <= w_in_now[TIME_W-1:0];
        end
    end

    assign w_diff   = r_now - r_rd_time;
    assign w_diff64 = 64'(w_diff);

    always_ff @(posedge i_clk) begin
        if (i_cmd.elap) begin
            r_elap <= (|w_diff64[63:ELAP_W]) ? '1 : w_diff64[ELAP_W-1:0];
            r_new  <= !r_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_added <= r_elap * r_rate;
        end
    end

    assign w_cap_eff = (r_cap < ONE_TOKEN) ? ONE_TOKEN : r_cap;
    assign w_room    = w_cap_eff - r_rd_lvl;
    assign w_full    = (r_rd_lvl >= w_cap_eff) || (r_added >= PROD_W'(w_room));

    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp) begin
            if (r_new || w_full) begin
                r_lvl <= w_cap_eff;
            end else begin
                r_lvl <= r_rd_lvl + r_added[LVL_W-1:0];
            end
        end
    end

    assign w_allow   = (r_lvl >= ONE_TOKEN);
    assign w_fin_lvl = w_allow ? (r_lvl - ONE_TOKEN) : r_lvl;

    assign o_sts.out_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_out_allowed <= w_allow;
            r_out_tokens  <= w_fin_lvl;
            r_out_new     <= r_new;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_DATA_W - LVL_W - 2)'(0), r_out_new, r_out_tokens,
                            r_out_allowed};

    a_fin_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin |=> r_out_valid)
        else $error("finished result not presented");

    a_refused_below_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_allowed) |-> r_out_tokens < ONE_TOKEN)
        else $error("request refused with a whole token present");

    a_new_is_allowed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_new) |-> r_out_allowed)
        else $error("new bucket refused its first request");

endmodule

>>> src/per_flow_token_bucket_policer_unit.sv
// Per-flow token bucket policer. Each input transfer names a flow and a timestamp; each
// produces exactly one result transfer carrying the admit decision, the bucket level left
// (Q16.32) and whether the bucket was created by this request. Token levels and refill
// times live in single-port memories of NUM_FLOWS entries, so requests are handled one at
// a time: the table is read at acceptance and the result is registered after the steps
// elapsed time, refill multiply, clip at capacity, and charge and write back, the last of
// which waits while the output register is full. After reset a clearing pass over all
// NUM_FLOWS (1024) entries marks every bucket absent, accepting config writes but no input.
// Configuration must be written only while the block is idle; the block does not check it.
module per_flow_token_bucket_policer_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // flow_index[9:0], now_ticks[57:10], zero fill above
    input  logic [ftbp_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // allowed[0], tokens_left[48:1], new_flow[49], zero fill above
    output logic [ftbp_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ftbp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ftbp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import ftbp_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    ftbp_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_sts         (w_sts),
        .o_cmd         (w_cmd)
    );

    ftbp_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts)
    );

endmodule

>>> tb/ftbp_policer_checker.sv
module ftbp_policer_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_req_valid,
    input  logic                            i_req_ready,
    input  logic [ftbp_pkg::IN_DATA_W-1:0]  i_req_data,
    input  logic                            i_res_valid,
    input  logic                            i_res_ready,
    input  logic [ftbp_pkg::OUT_DATA_W-1:0] i_res_data,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [ftbp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ftbp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_errors,
    output int                              o_pending,
    output int                              o_admitted,
    output int                              o_refused,
    output int                              o_created
);
    timeunit 1ns;
    timeprecision 1ps;

    import ftbp_pkg::*;

    typedef struct packed {
        logic             allowed;
        logic [LVL_W-1:0] tokens_left;
        logic             new_flow;
    } t_verdict;

    logic [RATE_W-1:0]    rate_reg;
    logic [LVL_W-1:0]     capacity_reg;
    logic [NUM_FLOWS-1:0] bucket_live;
    logic [LVL_W-1:0]     bucket_level [NUM_FLOWS];
    logic [TIME_W-1:0]    last_seen    [NUM_FLOWS];
    t_verdict             verdict_q[$];

    function automatic t_verdict police_request(input logic [IDX_W-1:0] flow,
                                                input logic [NOW_W-1:0] now);
        t_verdict          v;
        logic [LVL_W-1:0]  cap;
        logic [LVL_W-1:0]  lvl;
        logic [TIME_W-1:0] elapsed;
        logic [ELAP_W-1:0] elapsed_sat;
        logic [PROD_W-1:0] gain;
        v = '0;
        cap = (capacity_reg < ONE_TOKEN) ? ONE_TOKEN : capacity_reg;
        if (!bucket_live[flow]) begin
            bucket_live[flow] = 1'b1;
            lvl = cap;
            v.new_flow = 1'b1;
        end else begin
            elapsed = now[TIME_W-1:0] - last_seen[flow];
            elapsed_sat = (elapsed > TIME_W'({ELAP_W{1'b1}})) ? '1 : elapsed[ELAP_W-1:0];
            gain = PROD_W'(elapsed_sat) * PROD_W'(rate_reg);
            lvl = bucket_level[flow];
            if (lvl >= cap || gain >= PROD_W'(cap - lvl)) begin
                lvl = cap;
            end else begin
                lvl = lvl + gain[LVL_W-1:0];
            end
        end
        last_seen[flow] = now[TIME_W-1:0];
        if (lvl >= ONE_TOKEN) begin
            lvl = lvl - ONE_TOKEN;
            v.allowed = 1'b1;
        end
        bucket_level[flow] = lvl;
        v.tokens_left = lvl;
        return v;
    endfunction

    always @(posedge i_clk) begin
        t_verdict got;
        t_verdict want;
        if (!i_rst_n) begin
            rate_reg = '0;
            capacity_reg = ONE_TOKEN;
            bucket_live = '0;
            verdict_q.delete();
            o_errors = 0;
            o_admitted = 0;
            o_refused = 0;
            o_created = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_REFILL_RATE: rate_reg = i_cfg_data[RATE_W-1:0];
                    CFG_CAPACITY:    capacity_reg = i_cfg_data[LVL_W-1:0];
                    default: ;
                endcase
            end
            if (i_res_valid && i_res_ready) begin
                got.allowed = i_res_data[0];
                got.tokens_left = i_res_data[1 +: LVL_W];
                got.new_flow = i_res_data[LVL_W+1];
                if (verdict_q.size() == 0) begin
                    $error("Result transfer with no request outstanding: data %h", i_res_data);
                    o_errors++;
                end else begin
                    want = verdict_q.pop_front();
                    if (got.allowed !== want.allowed) begin
                        $error("allowed mismatch: expected %0d, actual %0d",
                               want.allowed, got.allowed);
                        o_errors++;
                    end
                    if (got.tokens_left !== want.tokens_left) begin
                        $error("tokens_left mismatch: expected %h, actual %h",
                               want.tokens_left, got.tokens_left);
                        o_errors++;
                    end
                    if (got.new_flow !== want.new_flow) begin
                        $error("new_flow mismatch: expected %0d, actual %0d",
                               want.new_flow, got.new_flow);
                        o_errors++;
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                want = police_request(i_req_data[IDX_W-1:0], i_req_data[IDX_W +: NOW_W]);
                verdict_q.push_back(want);
                if (want.allowed) begin
                    o_admitted++;
                end else begin
                    o_refused++;
                end
                if (want.new_flow) begin
                    o_created++;
                end
            end
        end
        o_pending = verdict_q.size();
    end

endmodule

>>> tb/per_flow_token_bucket_policer_unit_tb.sv
module per_flow_token_bucket_policer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ftbp_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 222;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LOW  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HIGH = '1;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int errors;
    int pending;
    int admitted;
    int refused;
    int created;

    logic             req_taken = 1'b0;
    logic             cfg_taken = 1'b0;
    logic             hold_wanted = 1'b0;
    int               cycle_count = 0;
    int               burst_left = 0;
    int               max_gap = 8;
    int               reg_writes = 0;
    logic [NOW_W-1:0] ticks;
    logic [IDX_W-1:0] last_flow = '0;

    per_flow_token_bucket_policer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    ftbp_policer_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .i_req_ready (s_axis_tready),
        .i_req_data  (s_axis_tdata),
        .i_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .i_res_data  (m_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_admitted  (admitted),
        .o_refused   (refused),
        .o_created   (created)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        req_taken <= s_axis_tvalid && s_axis_tready;
        cfg_taken <= i_cfg_valid && o_cfg_ready;
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // The receiver runs its own stall pattern; once asked, it holds off for a long
    // stretch so that the pipeline backs up and the request side stalls.
    initial begin
        int mode;
        int seg;
        m_axis_tready = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            seg = $urandom_range(8, 64);
            repeat (seg) begin
                @(negedge i_clk);
                if (hold_wanted) begin
                    hold_wanted = 1'b0;
                    m_axis_tready = 1'b0;
                    repeat (LONG_HOLD) @(negedge i_clk);
                end
                case (mode)
                    0, 1:    m_axis_tready = 1'b1;
                    2:       m_axis_tready = 1'($urandom_range(0, 1));
                    default: m_axis_tready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    function automatic logic [NOW_W-1:0] random_ticks();
        return NOW_W'({$urandom, $urandom});
    endfunction

    task automatic send_request(input logic [IDX_W-1:0] flow, input logic [NOW_W-1:0] ts);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, max_gap);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {{(IN_DATA_W - IDX_W - NOW_W){1'b0}}, ts, flow};
        do @(negedge i_clk); while (!req_taken);
        burst_left--;
    endtask

    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        i_cfg_valid = 1'b1;
        i_cfg_index = index;
        i_cfg_data = value;
        do @(negedge i_clk); while (!cfg_taken);
        i_cfg_valid = 1'b0;
        reg_writes++;
    endtask

    task automatic run_phase(input int count, input int pool);
        int               pick;
        logic [IDX_W-1:0] flow;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                flow = IDX_W'($urandom_range(0, pool - 1));
                ticks = ticks + NOW_W'($urandom_range(0, 8));
            end else if (pick < 85) begin
                flow = IDX_W'($urandom_range(0, NUM_FLOWS - 1));
                ticks = ticks + NOW_W'($urandom_range(0, 3));
            end else if (pick < 93) begin
                flow = last_flow;
                ticks = ticks + NOW_W'($urandom_range(0, 1));
            end else begin
                flow = IDX_W'($urandom_range(0, pool - 1));
                ticks = random_ticks();
            end
            last_flow = flow;
            send_request(flow, ticks);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_request(IDX_W'(0), NOW_W'(0));
        send_request(IDX_W'(0), NOW_W'(0));
        send_request(IDX_W'(NUM_FLOWS - 1), '1);
        wait_drained();

        write_register(CFG_REFILL_RATE, '1);
        write_register(CFG_CAPACITY, '0);
        send_request(IDX_W'(0), '1);
        send_request(IDX_W'(NUM_FLOWS - 1), NOW_W'(5));
        send_request(IDX_W'(NUM_FLOWS - 1), NOW_W'(5));
        wait_drained();

        write_register(CFG_CAPACITY, '1);
        write_register(CFG_REFILL_RATE, '0);
        send_request(IDX_W'(512), NOW_W'(48'h5555_5555_5555));
        send_request(IDX_W'(512), NOW_W'(48'h5555_5555_5555));
        wait_drained();

        write_register(CFG_CAPACITY, CFG_DATA_W'(48'h3_0000_0000));
        write_register(CFG_UNUSED_LOW, '1);
        write_register(CFG_UNUSED_HIGH, '0);
        repeat (4) send_request(IDX_W'(512), NOW_W'(48'h5555_5555_5555));
        wait_drained();

        write_register(CFG_REFILL_RATE, CFG_DATA_W'(32'h8000_0000));
        send_request(IDX_W'(512), NOW_W'(48'h5555_5555_5556));
        send_request(IDX_W'(512), NOW_W'(48'h5555_5555_5558));
        send_request(IDX_W'(10'h2AA), NOW_W'(48'hAAAA_AAAA_AAAA));
        send_request(IDX_W'(10'h155), NOW_W'(0));
        send_request(IDX_W'(10'h2AA), NOW_W'(48'hAAAB_AAAA_AAAA));
        wait_drained();

        write_register(CFG_CAPACITY, CFG_DATA_W'(48'h0000_FFFF_FFFF));
        send_request(IDX_W'(10'h155), NOW_W'(1));
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            ticks = random_ticks();
            max_gap = 8;
            case (p)
                0: begin
                    write_register(CFG_REFILL_RATE,
                                   CFG_DATA_W'($urandom_range(32'h0800_0000, 32'h8000_0000)));
                    write_register(CFG_CAPACITY, CFG_DATA_W'(48'h4_0000_0000));
                end
                1: begin
                    write_register(CFG_REFILL_RATE, CFG_DATA_W'(32'hFFFF_FFFF));
                    write_register(CFG_CAPACITY, '1);
                    ticks = NOW_W'(48'hFFFF_FFFF_FE00);
                    max_gap = 0;
                end
                2: begin
                    write_register(CFG_REFILL_RATE, '0);
                    write_register(CFG_CAPACITY, CFG_DATA_W'(ONE_TOKEN));
                end
                3: begin
                    write_register(CFG_REFILL_RATE, CFG_DATA_W'($urandom));
                    write_register(CFG_CAPACITY,
                                   CFG_DATA_W'({16'($urandom_range(1, 16)), 32'($urandom)}));
                    hold_wanted = 1'b1;
                end
                4: begin
                    write_register(CFG_REFILL_RATE, CFG_DATA_W'($urandom_range(1, 32'h0010_0000)));
                    write_register(CFG_CAPACITY, CFG_DATA_W'(random_ticks()));
                end
                default: begin
                    write_register(CFG_REFILL_RATE, CFG_DATA_W'(random_ticks()));
                    write_register(CFG_CAPACITY, CFG_DATA_W'($urandom));
                end
            endcase
            write_register(CFG_IDX_W'($urandom_range(2, 255)), CFG_DATA_W'(random_ticks()));
            run_phase(PHASE_ITEMS, $urandom_range(4, 32));
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("Policed %0d requests across %0d register writes and %0d random phases.",
                 admitted + refused, reg_writes, PHASES);
        $display("Outcome mix: %0d admitted, %0d refused, %0d buckets created.",
                 admitted, refused, created);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
